// ===== rtl/core/ssplit_pkg.sv =====
// Shared types, constants and byte classification for the SQL statement splitter.
`default_nettype none

package ssplit_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned SSPLIT_QUEUE_DEPTH = 4;

  // Request types on the input channel.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOI  = 1'b1;

  // Byte values that the scanner reacts to.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Scan modes, encoded as they appear on the result channel.
  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_SQ      = 3'd1,
    MODE_SQ_ESC  = 3'd2,
    MODE_DQ      = 3'd3,
    MODE_DQ_ESC  = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_DOTCMD  = 3'd6
  } mode_t;

  // Classes that the front part assigns to each request.
  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_SEMI,
    CLS_SQUOTE,
    CLS_DQUOTE,
    CLS_DASH,
    CLS_E,
    CLS_DOT,
    CLS_NL,
    CLS_BSLASH,
    CLS_EOI
  } cls_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [7:0] char_byte;
    cls_t       cls;
    logic       boundary;
  } ssplit_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } ssplit_qstat_t;

  // Whitespace or punctuation in the C locale.
  function automatic logic is_boundary(input logic [7:0] c);
    logic res;
    res = (c == CH_SPACE) ||
          (c inside {[8'd9:8'd13], [8'd33:8'd47], [8'd58:8'd64],
                     [8'd91:8'd96], [8'd123:8'd126]});
    return res;
  endfunction

  // Map a byte onto the class the scanner acts upon.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t res;
    case (c)
      CH_SEMI:          res = CLS_SEMI;
      CH_SQUOTE:        res = CLS_SQUOTE;
      CH_DQUOTE:        res = CLS_DQUOTE;
      CH_DASH:          res = CLS_DASH;
      CH_LOW_E, CH_UP_E: res = CLS_E;
      CH_DOT:           res = CLS_DOT;
      CH_NL:            res = CLS_NL;
      CH_BSLASH:        res = CLS_BSLASH;
      default:          res = CLS_OTHER;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sql_statement_splitter_unit.sv =====
// Top level of the SQL statement splitter: front, queue and back parts.
//
// Usage: requests arrive on the in_ channel, one per cycle at most. A request
// is either a text byte (in_req_type low, byte on in_char_byte) or end of
// input (in_req_type high). Each request gives exactly one result on the out_
// channel: the echoed byte, a flag on the byte that ends a command (a
// semicolon in plain text, or the newline that ends a dot command), a flag
// when end of input drops a partial command, and the scan mode afterwards.
// Path: a request accepted on the in_ channel passes through the front holding
// register, the queue and the result register before it can be taken on the
// out_ channel.
// Throughput: one request per cycle while out_stall stays low, set by the scan-state
// update in the back part; the queue of QUEUE_DEPTH entries lets the front keep
// accepting while a result waits on a stalled receiver.
// Reset: synchronous on rst_n; the scanner starts in plain text at command
// start, and the queue and result register are emptied.
// When out_stall is high the result holds, the queue fills and then in_stall
// rises; nothing is lost or repeated.
`default_nettype none

module sql_statement_splitter_unit
  import ssplit_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SSPLIT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_char_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic            out_command_end,
  output logic            out_abandoned,
  output logic [2:0]      out_mode_after
);

  ssplit_qstat_t q_stat;
  ssplit_item_t  push_item;
  ssplit_item_t  head_item;
  logic          push;
  logic          pop;

  // Request intake and classification.
  ssplit_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_char_byte (in_char_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  // Decoupling queue.
  ssplit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // Scanner and result stage.
  ssplit_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_command_end (out_command_end),
    .out_abandoned   (out_abandoned),
    .out_mode_after  (out_mode_after)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ssplit_front.sv =====
// Front part: accepts requests, classifies each byte and pushes it into the queue.
`default_nettype none

module ssplit_front
  import ssplit_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_req_type,
  input  wire logic [7:0]    in_char_byte,
  input  wire ssplit_qstat_t q_stat,
  output logic               push,
  output ssplit_item_t       push_item
);

  logic         front_v_r;
  logic         front_v_nxt;
  ssplit_item_t item_r;
  ssplit_item_t item_nxt;
  logic         advance;

  // The holding register may refill whenever it is empty or drains this cycle.
  assign advance  = !front_v_r || !q_stat.full;
  assign in_stall = !advance;
  assign push     = front_v_r && !q_stat.full;
  assign push_item = item_r;

  // Classify the incoming request; end of input carries a zero byte.
  always_comb begin
    if (in_req_type == REQ_EOI) begin
      item_nxt.char_byte = CH_NUL;
      item_nxt.cls       = CLS_EOI;
      item_nxt.boundary  = 1'b0;
    end else begin
      item_nxt.char_byte = in_char_byte;
      item_nxt.cls       = classify(in_char_byte);
      item_nxt.boundary  = is_boundary(in_char_byte);
    end
  end

  assign front_v_nxt = advance ? in_valid : front_v_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  // Payload holding register.
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssplit_queue.sv =====
// Short queue of classified requests between the front and back parts.
`default_nettype none

module ssplit_queue
  import ssplit_pkg::*;
#(
  parameter int unsigned DEPTH = SSPLIT_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ssplit_item_t  push_item,
  input  wire logic          pop,
  output ssplit_item_t       head_item,
  output ssplit_qstat_t      q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ssplit_item_t     entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign head_item    = entry_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Occupancy never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy beyond depth");

  // A lone push raises the occupancy by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");

  // A pop is only ever issued with something stored.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/ssplit_back.sv =====
// Back part: scan-mode state machine and the registered result stage.
`default_nettype none

module ssplit_back
  import ssplit_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ssplit_qstat_t q_stat,
  input  wire ssplit_item_t  head_item,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char_out,
  output logic               out_command_end,
  output logic               out_abandoned,
  output logic [2:0]         out_mode_after
);

  // Scan state.
  mode_t mode_r, mode_nxt;
  logic  dash_r, dash_nxt;
  logic  pend_e_r, pend_e_nxt;
  logic  skip_r, skip_nxt;
  logic  prev_bnd_r, prev_bnd_nxt;
  logic  dot_ok_r, dot_ok_nxt;
  logic  has_r, has_nxt;

  // Result register.
  logic       out_v_r, out_v_nxt;
  logic [7:0] char_r;
  logic       end_r;
  logic       aband_r;
  mode_t      mode_out_r;

  // Values for the result being formed.
  logic       res_end;
  logic       res_aband;
  logic [7:0] res_char;

  logic is_eoi;
  logic pair_done;

  // Take the head request when the result register is free or being emptied.
  assign pop    = !q_stat.empty && (!out_v_r || !out_stall);
  assign is_eoi = (head_item.cls == CLS_EOI);

  // A pending dash or e/E completed by this byte.
  assign pair_done = (dash_r && head_item.cls == CLS_DASH) ||
                     (!dash_r && pend_e_r &&
                      (head_item.cls == CLS_SQUOTE || head_item.cls == CLS_DQUOTE));

  // Result fields for the head request.
  always_comb begin
    res_char  = head_item.char_byte;
    res_aband = is_eoi && has_r;
    res_end   = 1'b0;
    if (!is_eoi) begin
      case (mode_r)
        MODE_PLAIN:  res_end = !pair_done && (head_item.cls == CLS_SEMI);
        MODE_DOTCMD: res_end = (head_item.cls == CLS_NL);
        default:     res_end = 1'b0;
      endcase
    end
  end

  // Next scan state.
  always_comb begin
    mode_nxt     = mode_r;
    dash_nxt     = dash_r;
    pend_e_nxt   = pend_e_r;
    skip_nxt     = skip_r;
    prev_bnd_nxt = prev_bnd_r;
    dot_ok_nxt   = dot_ok_r;
    has_nxt      = has_r;
    if (pop) begin
      if (is_eoi || res_end) begin
        // End of input or end of command: start a fresh command.
        mode_nxt     = MODE_PLAIN;
        dash_nxt     = 1'b0;
        pend_e_nxt   = 1'b0;
        skip_nxt     = 1'b0;
        prev_bnd_nxt = 1'b1;
        dot_ok_nxt   = 1'b1;
        has_nxt      = 1'b0;
      end else begin
        has_nxt      = 1'b1;
        prev_bnd_nxt = head_item.boundary;
        case (mode_r)
          MODE_SQ: begin
            if (head_item.cls == CLS_SQUOTE) mode_nxt = MODE_PLAIN;
          end
          MODE_DQ: begin
            if (head_item.cls == CLS_DQUOTE) mode_nxt = MODE_PLAIN;
          end
          MODE_SQ_ESC: begin
            if (skip_r) begin
              skip_nxt = 1'b0;
            end else if (head_item.cls == CLS_SQUOTE) begin
              mode_nxt = MODE_PLAIN;
            end else if (head_item.cls == CLS_BSLASH) begin
              skip_nxt = 1'b1;
            end
          end
          MODE_DQ_ESC: begin
            if (skip_r) begin
              skip_nxt = 1'b0;
            end else if (head_item.cls == CLS_DQUOTE) begin
              mode_nxt = MODE_PLAIN;
            end else if (head_item.cls == CLS_BSLASH) begin
              skip_nxt = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (head_item.cls == CLS_NL) mode_nxt = MODE_PLAIN;
          end
          MODE_DOTCMD: begin
            mode_nxt = MODE_DOTCMD;
          end
          default: begin
            // Plain text: first resolve any pending lookahead.
            dash_nxt   = 1'b0;
            pend_e_nxt = dash_r ? pend_e_r : 1'b0;
            if (pair_done) begin
              if (dash_r) begin
                mode_nxt = MODE_COMMENT;
              end else if (head_item.cls == CLS_SQUOTE) begin
                mode_nxt = MODE_SQ_ESC;
              end else begin
                mode_nxt = MODE_DQ_ESC;
              end
            end else begin
              case (head_item.cls)
                CLS_SQUOTE: begin
                  mode_nxt   = MODE_SQ;
                  dot_ok_nxt = 1'b0;
                end
                CLS_DQUOTE: begin
                  mode_nxt   = MODE_DQ;
                  dot_ok_nxt = 1'b0;
                end
                CLS_DASH: begin
                  dash_nxt   = 1'b1;
                  dot_ok_nxt = 1'b0;
                end
                CLS_E: begin
                  if (prev_bnd_r) pend_e_nxt = 1'b1;
                  dot_ok_nxt = 1'b0;
                end
                CLS_DOT: begin
                  if (dot_ok_r) mode_nxt = MODE_DOTCMD;
                end
                CLS_NL: begin
                  dot_ok_nxt = 1'b0;
                end
                default: begin
                  dot_ok_nxt = dot_ok_r;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  // Result register holds until taken.
  assign out_v_nxt = pop ? 1'b1 : (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PLAIN;
      dash_r     <= 1'b0;
      pend_e_r   <= 1'b0;
      skip_r     <= 1'b0;
      prev_bnd_r <= 1'b1;
      dot_ok_r   <= 1'b1;
      has_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      dash_r     <= dash_nxt;
      pend_e_r   <= pend_e_nxt;
      skip_r     <= skip_nxt;
      prev_bnd_r <= prev_bnd_nxt;
      dot_ok_r   <= dot_ok_nxt;
      has_r      <= has_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      char_r     <= res_char;
      end_r      <= res_end;
      aband_r    <= res_aband;
      mode_out_r <= mode_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_char_out    = char_r;
  assign out_command_end = end_r;
  assign out_abandoned   = aband_r;
  assign out_mode_after  = mode_out_r;

  // A finished command always leaves the scanner in plain text.
  a_end_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && end_r |-> mode_out_r == MODE_PLAIN && !aband_r)
    else $error("command end without return to plain mode");

  // A dropped command is reported only for end of input.
  a_aband_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && aband_r |-> char_r == CH_NUL && mode_out_r == MODE_PLAIN)
    else $error("abandoned flag on a text byte");

  // Lookahead flags are never both pending.
  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(dash_r && pend_e_r))
    else $error("dash and e lookahead pending together");

  // The escape skip only lives inside an escaped string.
  a_skip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> mode_r == MODE_SQ_ESC || mode_r == MODE_DQ_ESC)
    else $error("escape skip outside an escaped string");

endmodule

`default_nettype wire
